// ===== rtl/frp_pkg.sv =====
// Flash erase range planner: shared types and constants.
// No dependencies; used by the interfaces and every module.
`default_nettype none

package frp_pkg;

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned EXT_W  = ADDR_W + 1;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_SUB  = 2'd1,
    KIND_SEC  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_WALK  = 2'd1,
    PH_ERROR = 2'd2
  } phase_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_NEXT = 1'b1
  } cmd_e;

  // decoded request held in the input register
  typedef struct packed {
    logic               load;
    logic               empty;
    logic               bad;
    logic [EXT_W-1:0]   range_end;
    logic [EXT_W-1:0]   head_end;
    logic [EXT_W-1:0]   sec_end;
    logic [ADDR_W-1:0]  cursor;
  } load_req_t;

  typedef struct packed {
    kind_e              kind;
    logic [ADDR_W-1:0]  addr;
    logic               fin;
    logic               err;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/frp_if.sv =====
// Request and result channel interfaces of the erase range planner.
// Depends on frp_pkg.
`default_nettype none

interface frp_req_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [frp_pkg::ADDR_W-1:0]  range_start;
  logic [frp_pkg::ADDR_W-1:0]  range_size;

  modport source (output valid, cmd, range_start, range_size, input ready);
  modport sink   (input valid, cmd, range_start, range_size, output ready);
endinterface

interface frp_res_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  erase_kind;
  logic [frp_pkg::ADDR_W-1:0]  erase_address;
  logic                        finished;
  logic                        range_error;

  modport source (output valid, erase_kind, erase_address, finished, range_error,
                  input ready);
  modport sink   (input valid, erase_kind, erase_address, finished, range_error,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/flash_erase_range_planner.sv =====
// Flash erase range planner top level: input register and range walker.
// Depends on frp_pkg, frp_if, frp_in_stage and frp_walker.
//
//   channel  modport  payload                                          role
//   req_i    sink     cmd, range_start, range_size                     load / next
//   res_o    source   erase_kind, erase_address, finished, range_error erase command
//
// One request per cycle sustained while the result channel is not stalled; a taken
// request goes into the input register, then its result into the result register.
// The 33-bit add and compare on the cursor in the walker sets the cycle time.
// Reset clears the valid flags and returns the walker to idle with no range loaded.
// A stalled result holds; requests keep flowing while either register has room.
`default_nettype none

module flash_erase_range_planner #(
  parameter int unsigned SECTOR_BYTES    = 65536,
  parameter int unsigned SUBSECTOR_BYTES = 4096
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  frp_req_if.sink   req_i,
  frp_res_if.source res_o
);

  logic               mid_valid, mid_ready;
  frp_pkg::load_req_t mid_req;
  frp_pkg::result_t   res;

  frp_in_stage #(
    .SECTOR_BYTES    (SECTOR_BYTES),
    .SUBSECTOR_BYTES (SUBSECTOR_BYTES)
  ) u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .cmd_i       (req_i.cmd),
    .start_i     (req_i.range_start),
    .size_i      (req_i.range_size),
    .out_valid_o (mid_valid),
    .out_ready_i (mid_ready),
    .out_o       (mid_req)
  );

  frp_walker #(
    .SECTOR_BYTES    (SECTOR_BYTES),
    .SUBSECTOR_BYTES (SUBSECTOR_BYTES)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mid_valid),
    .in_ready_o  (mid_ready),
    .in_i        (mid_req),
    .res_valid_o (res_o.valid),
    .res_ready_i (res_o.ready),
    .res_o       (res)
  );

  assign res_o.erase_kind    = res.kind;
  assign res_o.erase_address = res.addr;
  assign res_o.finished      = res.fin;
  assign res_o.range_error   = res.err;

endmodule

`default_nettype wire

// ===== rtl/frp_in_stage.sv =====
// Input register of the planner: takes a request and pre-decodes range bounds.
// Depends on frp_pkg.
`default_nettype none

module frp_in_stage #(
  parameter int unsigned SECTOR_BYTES    = 65536,
  parameter int unsigned SUBSECTOR_BYTES = 4096
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output      logic                        in_ready_o,
  input  wire logic                        cmd_i,
  input  wire logic [frp_pkg::ADDR_W-1:0]  start_i,
  input  wire logic [frp_pkg::ADDR_W-1:0]  size_i,
  output      logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  output      frp_pkg::load_req_t          out_o
);

  localparam int unsigned AddrW = frp_pkg::ADDR_W;
  localparam int unsigned ExtW  = frp_pkg::EXT_W;
  localparam logic [ExtW-1:0] SecMask = ExtW'(SECTOR_BYTES) - ExtW'(1);
  localparam logic [ExtW-1:0] SubMask = ExtW'(SUBSECTOR_BYTES) - ExtW'(1);
  localparam logic [ExtW-1:0] AddrTop = ExtW'(1) << AddrW;

  logic               valid_q;
  frp_pkg::load_req_t data_q, data_d;
  logic [ExtW-1:0]    start_w, end_w, head_up, sec_dn;
  logic               whole;

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = data_q;

  always_comb begin
    start_w = {1'b0, start_i};
    end_w   = start_w + {1'b0, size_i};
    head_up = (start_w + SecMask) & ~SecMask;
    sec_dn  = end_w & ~SecMask;
    whole   = head_up < sec_dn;

    data_d.load      = (frp_pkg::cmd_e'(cmd_i) == frp_pkg::CMD_LOAD);
    data_d.empty     = (size_i == '0);
    data_d.bad       = end_w > AddrTop;
    data_d.range_end = end_w;
    data_d.head_end  = whole ? head_up : end_w;
    data_d.sec_end   = whole ? sec_dn : end_w;
    data_d.cursor    = start_i & ~SubMask[AddrW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      data_q <= data_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/frp_walker.sv =====
// Range walker: holds the loaded range and cursor, issues one result, an erase or none, per request
// into the result register. Depends on frp_pkg.
`default_nettype none

module frp_walker #(
  parameter int unsigned SECTOR_BYTES    = 65536,
  parameter int unsigned SUBSECTOR_BYTES = 4096
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire frp_pkg::load_req_t  in_i,
  output      logic                res_valid_o,
  input  wire logic                res_ready_i,
  output      frp_pkg::result_t    res_o
);

  localparam int unsigned AddrW = frp_pkg::ADDR_W;
  localparam int unsigned ExtW  = frp_pkg::EXT_W;
  localparam logic [ExtW-1:0] SecBytes = ExtW'(SECTOR_BYTES);
  localparam logic [ExtW-1:0] SubBytes = ExtW'(SUBSECTOR_BYTES);

  frp_pkg::phase_e    phase_q, phase_d;
  logic [AddrW-1:0]   cursor_q, cursor_d;
  logic [ExtW-1:0]    head_q, sec_q, end_q;
  logic               res_valid_q;
  frp_pkg::result_t   res_q, res_d;

  logic               fire;
  logic [AddrW-1:0]   cur;
  logic [ExtW-1:0]    cur_w, head, sec, rend, nxt;
  logic               sec_kind, last;

  assign in_ready_o  = !res_valid_q || res_ready_i;
  assign fire        = in_valid_i && in_ready_o;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    cur      = in_i.load ? in_i.cursor    : cursor_q;
    head     = in_i.load ? in_i.head_end  : head_q;
    sec      = in_i.load ? in_i.sec_end   : sec_q;
    rend     = in_i.load ? in_i.range_end : end_q;
    cur_w    = {1'b0, cur};
    sec_kind = !(cur_w < head) && (cur_w < sec);
    nxt      = sec_kind ? (cur_w + SecBytes) : (cur_w + SubBytes);
    last     = nxt >= rend;
  end

  always_comb begin
    phase_d    = phase_q;
    cursor_d   = cursor_q;
    res_d.kind = frp_pkg::KIND_NONE;
    res_d.addr = '0;
    res_d.fin  = 1'b1;
    res_d.err  = 1'b0;
    if (fire) begin
      if (in_i.load && in_i.empty) begin
        phase_d = frp_pkg::PH_IDLE;
      end else if (in_i.load && in_i.bad) begin
        phase_d   = frp_pkg::PH_ERROR;
        res_d.err = 1'b1;
      end else if (in_i.load || phase_q == frp_pkg::PH_WALK) begin
        res_d.kind = sec_kind ? frp_pkg::KIND_SEC : frp_pkg::KIND_SUB;
        res_d.addr = cur;
        res_d.fin  = last;
        cursor_d   = nxt[AddrW-1:0];
        phase_d    = last ? frp_pkg::PH_IDLE : frp_pkg::PH_WALK;
      end else begin
        case (phase_q)
          frp_pkg::PH_ERROR: res_d.err = 1'b1;
          default:           res_d.err = 1'b0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= frp_pkg::PH_IDLE;
      cursor_q    <= '0;
      head_q      <= '0;
      sec_q       <= '0;
      end_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      cursor_q <= cursor_d;
      if (fire && in_i.load) begin
        head_q <= in_i.head_end;
        sec_q  <= in_i.sec_end;
        end_q  <= in_i.range_end;
      end
      if (in_ready_o) begin
        res_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

endmodule

`default_nettype wire

// ===== dv/frp_checker.sv =====
// Erase range planner checker: predicts each erase command from the accepted requests
// and compares it with the result channel. Depends on frp_pkg and frp_if.
`default_nettype none

module frp_checker #(
  parameter int unsigned SECTOR_BYTES    = 65536,
  parameter int unsigned SUBSECTOR_BYTES = 4096
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  frp_req_if        req_i,
  frp_res_if        res_i,
  output int        fail_count_o,
  output int        pending_o
);

  localparam int unsigned ADDR_W = frp_pkg::ADDR_W;
  localparam int unsigned EXT_W  = frp_pkg::EXT_W;
  localparam logic [EXT_W-1:0]  SEC_MASK  = EXT_W'(SECTOR_BYTES) - EXT_W'(1);
  localparam logic [ADDR_W-1:0] SUB_ALIGN = ~(ADDR_W'(SUBSECTOR_BYTES) - ADDR_W'(1));

  frp_pkg::phase_e   plan_phase;
  logic [ADDR_W-1:0] plan_cursor;
  logic [EXT_W-1:0]  plan_head_end;
  logic [EXT_W-1:0]  plan_sec_end;
  logic [EXT_W-1:0]  plan_range_end;

  frp_pkg::result_t commands_due[$];
  int               fails;

  function automatic frp_pkg::result_t next_block();
    frp_pkg::result_t r;
    logic [EXT_W-1:0] here;
    logic [EXT_W-1:0] block_end;
    here = {1'b0, plan_cursor};
    if (here < plan_head_end || here >= plan_sec_end) begin
      r.kind    = frp_pkg::KIND_SUB;
      block_end = here + EXT_W'(SUBSECTOR_BYTES);
    end else begin
      r.kind    = frp_pkg::KIND_SEC;
      block_end = here + EXT_W'(SECTOR_BYTES);
    end
    r.addr = here[ADDR_W-1:0];
    r.err  = 1'b0;
    if (block_end >= plan_range_end) begin
      plan_phase = frp_pkg::PH_IDLE;
      r.fin      = 1'b1;
    end else begin
      plan_cursor = block_end[ADDR_W-1:0];
      r.fin       = 1'b0;
    end
    return r;
  endfunction

  function automatic frp_pkg::result_t plan_request(frp_pkg::cmd_e cmd,
                                                    logic [ADDR_W-1:0] start,
                                                    logic [ADDR_W-1:0] size);
    frp_pkg::result_t r;
    logic [EXT_W-1:0] range_end;
    logic [EXT_W-1:0] head_end;
    logic [EXT_W-1:0] sec_end;
    r.kind = frp_pkg::KIND_NONE;
    r.addr = '0;
    r.fin  = 1'b1;
    r.err  = 1'b0;
    if (cmd == frp_pkg::CMD_LOAD) begin
      range_end = {1'b0, start} + {1'b0, size};
      if (size == '0) begin
        plan_phase = frp_pkg::PH_IDLE;
      end else if (range_end[ADDR_W] && range_end[ADDR_W-1:0] != '0) begin
        plan_phase = frp_pkg::PH_ERROR;
        r.err      = 1'b1;
      end else begin
        head_end = ({1'b0, start} + SEC_MASK) & ~SEC_MASK;
        sec_end  = range_end & ~SEC_MASK;
        // no whole sector: subsectors only
        if (head_end >= sec_end) begin
          head_end = range_end;
          sec_end  = range_end;
        end
        plan_head_end  = head_end;
        plan_sec_end   = sec_end;
        plan_range_end = range_end;
        plan_cursor    = start & SUB_ALIGN;
        plan_phase     = frp_pkg::PH_WALK;
        r              = next_block();
      end
    end else if (plan_phase == frp_pkg::PH_WALK) begin
      r = next_block();
    end else if (plan_phase == frp_pkg::PH_ERROR) begin
      r.err = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    frp_pkg::result_t want;
    if (!rst_ni) begin
      plan_phase     = frp_pkg::PH_IDLE;
      plan_cursor    = '0;
      plan_head_end  = '0;
      plan_sec_end   = '0;
      plan_range_end = '0;
      commands_due.delete();
      fails          = 0;
      fail_count_o  <= 0;
      pending_o     <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (commands_due.size() == 0) begin
          if (fails < 10)
            $display("unexpected result: kind %0d addr %h fin %0b err %0b",
                     res_i.erase_kind, res_i.erase_address, res_i.finished,
                     res_i.range_error);
          fails++;
        end else begin
          want = commands_due.pop_front();
          if (res_i.erase_kind !== want.kind || res_i.erase_address !== want.addr ||
              res_i.finished !== want.fin || res_i.range_error !== want.err) begin
            if (fails < 10)
              $display("mismatch: expected kind %0d addr %h fin %0b err %0b, got %0d %h %0b %0b",
                       want.kind, want.addr, want.fin, want.err, res_i.erase_kind,
                       res_i.erase_address, res_i.finished, res_i.range_error);
            fails++;
          end
        end
      end
      if (req_i.valid && req_i.ready)
        commands_due.push_back(plan_request(frp_pkg::cmd_e'(req_i.cmd),
                                            req_i.range_start, req_i.range_size));
      fail_count_o <= fails;
      pending_o    <= commands_due.size();
    end
  end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Erase range planner testbench top: clock, reset, request stimulus and result stalls.
// Depends on frp_pkg, frp_if, flash_erase_range_planner and frp_checker.
`default_nettype none

module testbench;

  localparam int unsigned SEC   = 65536;
  localparam int unsigned SUB   = 4096;
  localparam int          ITEMS = 1650;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  int   fails;
  int   expected_left;
  int   sent_count  = 0;
  int   got_count   = 0;
  int   done_index  = -1;
  bit   req_quiet   = 1'b0;
  bit   res_quiet   = 1'b0;

  always #5 clk_i = ~clk_i;

  frp_req_if req_ch();
  frp_res_if res_ch();

  flash_erase_range_planner #(
    .SECTOR_BYTES    (SEC),
    .SUBSECTOR_BYTES (SUB)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .res_o  (res_ch)
  );

  frp_checker #(
    .SECTOR_BYTES    (SEC),
    .SUBSECTOR_BYTES (SUB)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_ch),
    .res_i        (res_ch),
    .fail_count_o (fails),
    .pending_o    (expected_left)
  );

  // index of the latest finished result, to know when a walk is over
  always @(posedge clk_i) begin
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      if (res_ch.finished) done_index <= got_count;
      got_count <= got_count + 1;
    end
  end

  function automatic int draw_gap(bit quiet);
    return quiet ? 0 : $urandom_range(0, 12);
  endfunction

  task automatic send_req(frp_pkg::cmd_e cmd, logic [31:0] start, logic [31:0] size);
    int gap;
    if ($urandom_range(0, 29) == 0) req_quiet = !req_quiet;
    gap = draw_gap(req_quiet);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.cmd         <= cmd;
    req_ch.range_start <= start;
    req_ch.range_size  <= size;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    sent_count++;
  endtask

  // load a range, then ask for commands until it finishes or the cap is hit
  task automatic walk_range(logic [31:0] start, logic [31:0] size, int max_next);
    int load_idx;
    int n;
    load_idx = sent_count;
    n        = 0;
    send_req(frp_pkg::CMD_LOAD, start, size);
    while (done_index < load_idx && n < max_next) begin
      send_req(frp_pkg::CMD_NEXT, $urandom, $urandom);
      n++;
    end
  endtask

  task automatic random_range();
    logic [31:0] start;
    logic [31:0] size;
    case ($urandom_range(0, 3))
      0: start = $urandom & ~(SEC - 1);
      1: start = $urandom & ~(SUB - 1);
      2: start = $urandom;
      default: start = 32'hFFF0_0000 | ($urandom & 32'h000F_FFFF);
    endcase
    case ($urandom_range(0, 3))
      0: size = $urandom_range(1, 2 * SUB);
      1: size = $urandom_range(1, 2 * SEC);
      2: size = SEC * $urandom_range(1, 3);
      default: size = $urandom_range(1, 4 * SEC);
    endcase
    // keep it inside the address space, ending exactly at the top
    if ({1'b0, start} + {1'b0, size} > 33'h1_0000_0000) start = -size;
    if ($urandom_range(0, 9) == 0) walk_range(start, size, $urandom_range(0, 4));
    else walk_range(start, size, 200);
  endtask

  initial begin
    res_ch.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      int gap;
      if ($urandom_range(0, 29) == 0) res_quiet = !res_quiet;
      gap = draw_gap(res_quiet);
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!res_ch.valid) @(posedge clk_i);
    end
  end

  initial begin
    logic [31:0] start;
    int          pick;
    req_ch.valid       <= 1'b0;
    req_ch.cmd         <= frp_pkg::CMD_LOAD;
    req_ch.range_start <= '0;
    req_ch.range_size  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed
    send_req(frp_pkg::CMD_NEXT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    walk_range(32'h1234_5678, 32'h0, 1);
    walk_range(32'h0001_0000, SEC, 200);
    walk_range(32'h0, 32'h1, 200);
    walk_range(32'h0000_E123, 2 * SEC + 32'h2000, 200);
    walk_range(32'h0002_F800, 32'h1000, 200);
    walk_range(32'hFFFE_0000, 32'h0002_0000, 200);
    walk_range(32'hFFFF_F001, 32'h0000_0FFF, 200);
    walk_range(32'hFFFF_FFFF, 32'h2, 2);
    walk_range(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    walk_range(32'h0, 32'hFFFF_FFFF, 3);
    walk_range(32'h1, 32'hFFFF_FFFF, 2);

    // random
    while (sent_count < ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        random_range();
      end else if (pick < 85) begin
        walk_range($urandom, $urandom, $urandom_range(0, 3));
      end else if (pick < 92) begin
        start = 32'hFFFF_0000 | $urandom;
        walk_range(start, -start + $urandom_range(1, SEC), $urandom_range(0, 3));
      end else begin
        send_req(frp_pkg::CMD_NEXT, $urandom, $urandom);
      end
    end
    req_ch.valid <= 1'b0;

    @(posedge clk_i);
    wait (expected_left == 0);
    repeat (8) @(posedge clk_i);
    if (fails == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

`default_nettype wire
